// ===== hw/rtl/owtr_pkg.sv =====
package owtr_pkg;

    localparam int unsigned InWidth  = 5;
    localparam int unsigned OutWidth = 24;
    localparam int unsigned QDepth   = 2;

    localparam logic [7:0] CmdSkipRom = 8'hCC;
    localparam logic [7:0] CmdConvert = 8'h44;
    localparam logic [7:0] CmdReadSp  = 8'hBE;
    localparam logic [7:0] DoneCode   = 8'hFF;
    localparam logic [2:0] MaxStatusReads = 3'd3;

    localparam logic [2:0] RegRstLow  = 3'd0;
    localparam logic [2:0] RegPres    = 3'd1;
    localparam logic [2:0] RegRec     = 3'd2;
    localparam logic [2:0] RegSlotLow = 3'd3;
    localparam logic [2:0] RegSample  = 3'd4;
    localparam logic [2:0] RegRest    = 3'd5;
    localparam logic [2:0] RegConv    = 3'd6;
    localparam logic [2:0] RegRetry   = 3'd7;

    typedef enum logic [13:0] {
        PH_IDLE       = 14'b00000000000001,
        PH_RST1       = 14'b00000000000010,
        PH_W_SKIP1    = 14'b00000000000100,
        PH_W_CONV     = 14'b00000000001000,
        PH_CONV_WAIT  = 14'b00000000010000,
        PH_RD_STATUS  = 14'b00000000100000,
        PH_RETRY_WAIT = 14'b00000001000000,
        PH_RD_FINAL   = 14'b00000010000000,
        PH_RST2       = 14'b00000100000000,
        PH_W_SKIP2    = 14'b00001000000000,
        PH_W_RDSP     = 14'b00010000000000,
        PH_RD_LSB     = 14'b00100000000000,
        PH_RD_SIGN    = 14'b01000000000000,
        PH_RST3       = 14'b10000000000000
    } t_phase;

    // decoded input beat from the front part
    typedef struct packed {
        logic strobe;
        logic start;
        logic sel;
        logic line_a;
        logic line_b;
    } t_item;

    // timing registers
    typedef struct packed {
        logic [9:0]  rst_low;
        logic [9:0]  pres;
        logic [9:0]  rec;
        logic [5:0]  slot_low;
        logic [5:0]  sample;
        logic [7:0]  rest;
        logic [19:0] conv;
        logic [19:0] retry;
    } t_cfg;

endpackage

// ===== hw/rtl/onewire_temp_sensor_reader.sv =====
// channel  | dir | beat fields (low bit up)
// s_axis   | in  | us_strobe, start_req, sensor_select, line_a, line_b
// m_axis   | out | drive_low_a, drive_low_b, busy_res, done_pulse, ok,
//          |     | temperature_tenths[10:0], sign_byte[7:0]
// cfg      | in  | index 0..7 timing registers, data up to 20 bits
// one input beat gives one output beat; one beat per cycle sustained while m_axis is not stalled
// each beat passes the front queue register, then the output register
// the two-entry queue and the output register let each side stall alone
// a stalled output holds the sequencer, which advances only on taken beats
// reset is synchronous active low and loads the default timings
module onewire_temp_sensor_reader
    import owtr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // us_strobe, start_req, sensor_select, line_a, line_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // drive_low_a, drive_low_b, busy_res, done_pulse, ok,
                                        // temperature_tenths, sign_byte
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_q_valid, w_q_ready;
    t_item w_q_item;

    assign o_cfg_ready = 1'b1;

    // timing register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rst_low <= 10'd500; r_cfg.pres <= 10'd70; r_cfg.rec <= 10'd300;
            r_cfg.slot_low <= 6'd5; r_cfg.sample <= 6'd5; r_cfg.rest <= 8'd60;
            r_cfg.conv <= 20'd500000; r_cfg.retry <= 20'd100000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegRstLow:  r_cfg.rst_low  <= i_cfg_data[9:0];
                RegPres:    r_cfg.pres     <= i_cfg_data[9:0];
                RegRec:     r_cfg.rec      <= i_cfg_data[9:0];
                RegSlotLow: r_cfg.slot_low <= i_cfg_data[5:0];
                RegSample:  r_cfg.sample   <= i_cfg_data[5:0];
                RegRest:    r_cfg.rest     <= i_cfg_data[7:0];
                RegConv:    r_cfg.conv     <= i_cfg_data;
                RegRetry:   r_cfg.retry    <= i_cfg_data;
                default:    r_cfg.retry    <= r_cfg.retry;
            endcase
        end
    end

    owtr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .o_q_valid(w_q_valid), .i_q_ready(w_q_ready), .o_q_item(w_q_item)
    );

    owtr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_q_valid), .o_q_ready(w_q_ready), .i_q_item(w_q_item),
        .i_cfg(r_cfg),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

endmodule

// ===== hw/rtl/owtr_front.sv =====
module owtr_front
    import owtr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    output logic                o_q_valid,
    input  logic                i_q_ready,
    output t_item               o_q_item
);

    t_item            r_q [QDepth];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;
    t_item            w_item;

    // unpack the beat: strobe, start, select, line a, line b
    assign w_item.strobe = s_axis_tdata[0];
    assign w_item.start  = s_axis_tdata[1];
    assign w_item.sel    = s_axis_tdata[2];
    assign w_item.line_a = s_axis_tdata[3];
    assign w_item.line_b = s_axis_tdata[4];

    assign s_axis_tready = (r_cnt != 2'(QDepth));
    assign w_push = s_axis_tvalid && s_axis_tready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop = o_q_valid && i_q_ready;
    assign o_q_item = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_item;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDepth)) else $error("queue overfilled");
    a_full_noready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QDepth)) |-> !s_axis_tready) else $error("ready while full");
    a_empty_novalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_q_valid) else $error("valid while empty");
`endif

endmodule

// ===== hw/rtl/owtr_back.sv =====
module owtr_back
    import owtr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  t_item               i_q_item,
    input  t_cfg                i_cfg,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata
);

    t_phase      r_phase, n_phase;
    logic        r_sel, n_sel;
    logic [19:0] r_timer, n_timer;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [2:0]  r_reads, n_reads;
    logic [7:0]  r_low, n_low;
    logic [7:0]  r_sign, n_sign;
    logic [10:0] r_tenths, n_tenths;
    logic        r_ok, n_ok;
    logic [1:0]  r_sub, n_sub;
    logic        n_done, n_drive;
    logic        r_ovalid;
    logic [23:0] r_odata;
    logic        w_step;
    logic        w_line;
    logic [7:0]  w_t;

    function automatic logic is_rst(t_phase p);
        return p == PH_RST1 || p == PH_RST2 || p == PH_RST3;
    endfunction
    function automatic logic is_wr(t_phase p);
        return p == PH_W_SKIP1 || p == PH_W_CONV || p == PH_W_SKIP2 || p == PH_W_RDSP;
    endfunction
    function automatic logic is_rd(t_phase p);
        return p == PH_RD_STATUS || p == PH_RD_FINAL || p == PH_RD_LSB || p == PH_RD_SIGN;
    endfunction

    // output register takes a new beat whenever empty or being drained
    assign o_q_ready = !r_ovalid || m_axis_tready;
    assign w_step = i_q_valid && o_q_ready;
    assign w_line = r_sel ? i_q_item.line_b : i_q_item.line_a;
    assign w_t = (r_sign == 8'hFF) ? (8'd0 - r_low) : r_low;

    // sequencer next state
    always_comb begin
        t_phase ep;
        logic   do_enter;
        n_phase = r_phase; n_sel = r_sel; n_timer = r_timer; n_bit = r_bit;
        n_shift = r_shift; n_reads = r_reads; n_low = r_low; n_sign = r_sign;
        n_tenths = r_tenths; n_ok = r_ok; n_sub = r_sub; n_done = 1'b0;
        ep = PH_IDLE; do_enter = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_q_item.start) begin
                n_sel = i_q_item.sel; n_reads = 3'd0;
                ep = PH_RST1; do_enter = 1'b1;
            end
        end else if (i_q_item.strobe) begin
            if (r_timer > 20'd1) begin
                n_timer = r_timer - 20'd1;
            end else begin
                logic fin;
                fin = 1'b0;
                if (is_rst(r_phase)) begin
                    if (r_sub == 2'd0) begin
                        n_sub = 2'd1; n_timer = {10'd0, i_cfg.pres};
                    end else if (r_sub == 2'd1) begin
                        n_sub = 2'd2; n_timer = {10'd0, i_cfg.rec};
                    end else fin = 1'b1;
                end else if (is_wr(r_phase)) begin
                    if (r_sub == 2'd0) begin
                        n_sub = 2'd1; n_timer = {12'd0, i_cfg.rest};
                    end else begin
                        n_shift = r_shift >> 1;
                        if (r_bit == 3'd7) fin = 1'b1;
                        else begin
                            n_bit = r_bit + 3'd1; n_sub = 2'd0;
                            n_timer = {14'd0, i_cfg.slot_low};
                        end
                    end
                end else if (is_rd(r_phase)) begin
                    if (r_sub == 2'd0) begin
                        n_sub = 2'd1; n_timer = {14'd0, i_cfg.sample};
                    end else if (r_sub == 2'd1) begin
                        n_shift = {w_line, r_shift[7:1]};
                        n_sub = 2'd2; n_timer = {12'd0, i_cfg.rest};
                    end else begin
                        if (r_bit == 3'd7) fin = 1'b1;
                        else begin
                            n_bit = r_bit + 3'd1; n_sub = 2'd0;
                            n_timer = {14'd0, i_cfg.slot_low};
                        end
                    end
                end else fin = 1'b1;
                if (fin) begin
                    do_enter = 1'b1;
                    case (r_phase)
                        PH_RST1:       ep = PH_W_SKIP1;
                        PH_W_SKIP1:    ep = PH_W_CONV;
                        PH_W_CONV:     ep = PH_CONV_WAIT;
                        PH_CONV_WAIT: begin
                            n_reads = 3'd0; ep = PH_RD_STATUS;
                        end
                        PH_RD_STATUS:
                            ep = (n_shift == DoneCode) ? PH_RD_FINAL : PH_RETRY_WAIT;
                        PH_RETRY_WAIT: begin
                            n_reads = r_reads + 3'd1;
                            ep = (n_reads < MaxStatusReads) ? PH_RD_STATUS : PH_RD_FINAL;
                        end
                        PH_RD_FINAL: begin
                            if (n_shift == DoneCode) ep = PH_RST2;
                            else begin
                                do_enter = 1'b0; n_phase = PH_IDLE; n_sub = 2'd0;
                                n_timer = 20'd0; n_done = 1'b1; n_ok = 1'b0;
                                n_tenths = 11'd0; n_sign = 8'd0;
                            end
                        end
                        PH_RST2:    ep = PH_W_SKIP2;
                        PH_W_SKIP2: ep = PH_W_RDSP;
                        PH_W_RDSP:  ep = PH_RD_LSB;
                        PH_RD_LSB: begin
                            n_low = n_shift; ep = PH_RD_SIGN;
                        end
                        PH_RD_SIGN: begin
                            logic [7:0] t;
                            t = (n_shift == 8'hFF) ? (8'd0 - r_low) : r_low;
                            n_sign = n_shift;
                            n_tenths = 11'({3'd0, t[7:1]} * 11'd10)
                                + (t[0] ? 11'd5 : 11'd0);
                            ep = PH_RST3;
                        end
                        PH_RST3: begin
                            do_enter = 1'b0; n_phase = PH_IDLE; n_sub = 2'd0;
                            n_timer = 20'd0; n_done = 1'b1; n_ok = 1'b1;
                        end
                        default: begin
                            do_enter = 1'b0; n_phase = PH_IDLE; n_sub = 2'd0;
                            n_timer = 20'd0; n_done = 1'b1; n_ok = 1'b0;
                            n_tenths = 11'd0; n_sign = 8'd0;
                        end
                    endcase
                end
            end
        end
        // phase entry loads
        if (do_enter) begin
            n_phase = ep; n_bit = 3'd0; n_sub = 2'd0;
            if (is_rst(ep)) n_timer = {10'd0, i_cfg.rst_low};
            else if (is_wr(ep)) begin
                n_shift = (ep == PH_W_CONV) ? CmdConvert
                        : (ep == PH_W_RDSP) ? CmdReadSp : CmdSkipRom;
                n_timer = {14'd0, i_cfg.slot_low};
            end else if (is_rd(ep)) begin
                n_shift = 8'd0; n_timer = {14'd0, i_cfg.slot_low};
            end else if (ep == PH_CONV_WAIT) n_timer = i_cfg.conv;
            else if (ep == PH_RETRY_WAIT) n_timer = i_cfg.retry;
        end
        // line drive from the new state
        n_drive = ((is_rst(n_phase) || is_wr(n_phase) || is_rd(n_phase)) && n_sub == 2'd0)
               || (is_wr(n_phase) && n_sub == 2'd1 && !n_shift[0]);
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_sel <= 1'b0; r_timer <= 20'd0; r_bit <= 3'd0;
            r_shift <= 8'd0; r_reads <= 3'd0; r_low <= 8'd0; r_sign <= 8'd0;
            r_tenths <= 11'd0; r_ok <= 1'b0; r_sub <= 2'd0;
        end else if (w_step) begin
            r_phase <= n_phase; r_sel <= n_sel; r_timer <= n_timer; r_bit <= n_bit;
            r_shift <= n_shift; r_reads <= n_reads; r_low <= n_low; r_sign <= n_sign;
            r_tenths <= n_tenths; r_ok <= n_ok; r_sub <= n_sub;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_step) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (w_step)
            r_odata <= {n_sign, n_tenths, n_ok, n_done, (n_phase != PH_IDLE),
                        n_drive && n_sel, n_drive && !n_sel};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase)) else $error("phase not one-hot");
    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_sub == 2'd0)) else $error("sub-step in idle");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ok |-> (r_tenths == 11'd0 || r_phase != PH_IDLE))
        else $error("failure with nonzero temperature");
    a_sign_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RST3) |-> (w_t == ((r_sign == 8'hFF) ? 8'd0 - r_low : r_low)))
        else $error("sign path");
`endif

endmodule
